FILE: sv/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, constants and the exp2 fraction table for the softmax block.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int SCORE_W = 16;
   localparam int PROB_W  = 16;
   localparam int SUM_W   = 23;
   localparam logic [16:0] LOG2E_Q = 17'd94548;

   typedef struct packed {
      logic load;
      logic clear;
      logic exp_start;
      logic div_start;
      logic emit;
   } smx_cmd_type;

   typedef struct packed {
      logic exp_done;
      logic div_done;
      logic last_idx;
      logic full;
   } smx_status_type;

   function automatic logic [16:0] exp2_tbl(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd62757;
         5'd2:  v = 17'd60097;
         5'd3:  v = 17'd57549;
         5'd4:  v = 17'd55109;
         5'd5:  v = 17'd52773;
         5'd6:  v = 17'd50535;
         5'd7:  v = 17'd48393;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         5'd16: v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/smx_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_exp
// Three-stage e^(-d) unit: scale by log2(e), table interpolate, shift/round.
// ----------------------------------------------------------------------------
module smx_exp (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] diff,
   output logic        done,
   output logic [15:0] result
);
   import smx_pkg::*;

   logic [32:0] t_ff, t_in;
   logic [16:0] m_ff, m_in;
   logic [16:0] n_ff;
   logic [15:0] r_ff, r_in;
   logic [2:0]  v_ff;
   logic [16:0] a, b, dlt;
   logic [28:0] prod;
   logic [3:0]  idx;
   logic [17:0] rnd;
   logic [4:0]  sh;

   assign t_in = 33'((34'(diff) * 34'(LOG2E_Q)) >> 8);
   assign idx  = t_ff[15:12];
   assign a    = exp2_tbl({1'b0, idx});
   assign b    = exp2_tbl(5'({1'b0, idx} + 5'd1));
   assign dlt  = a - b;
   assign prod = 29'(dlt) * 29'(t_ff[11:0]);
   assign m_in = a - 17'(prod >> 12);

   always_comb begin
      sh  = n_ff[4:0];
      rnd = 18'(m_ff);
      if (n_ff == 17'd0) begin
         r_in = (m_ff > 17'd65535) ? 16'hFFFF : m_ff[15:0];
      end else if (n_ff <= 17'd16) begin
         rnd  = (18'(m_ff) + (18'd1 << (sh - 5'd1))) >> sh;
         r_in = (rnd > 18'd65535) ? 16'hFFFF : rnd[15:0];
      end else begin
         r_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      m_ff   <= m_in;
      n_ff   <= t_ff[32:16];
      r_ff   <= r_in;
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], start};
      end
   end

   assign done   = v_ff[2];
   assign result = r_ff;
endmodule

FILE: sv/smx_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_div
// Restoring divider, one quotient bit per cycle: (num << 16) / den, saturated.
// ----------------------------------------------------------------------------
module smx_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] num,
   input  logic [22:0] den,
   output logic        done,
   output logic [15:0] quot
);
   import smx_pkg::*;

   logic [31:0] q_ff, q_in;
   logic [23:0] r_ff, r_in;
   logic [22:0] d_ff;
   logic [5:0]  c_ff, c_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [23:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      c_in = c_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[22:0], q_ff[31]};
      if (start) begin
         q_in = {num, 16'd0};
         r_in = 24'd0;
         c_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[30:0], 1'b0};
         end
         c_in = c_ff + 6'd1;
         if (c_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      c_ff <= c_in;
      if (start) begin
         d_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = (d_ff == 23'd0) ? 16'd0 : ((q_ff[31:16] != 16'd0) ? 16'hFFFF : q_ff[15:0]);
endmodule

FILE: sv/smx_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_datapath
// Score/exp stores, running max, index counter, sum, exp and divide units.
// ----------------------------------------------------------------------------
module smx_datapath #(
   parameter int MAX_LEN = 64,
   parameter int IDX_W   = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  smx_pkg::smx_cmd_type   cmd,
   input  logic [15:0]            score,
   output smx_pkg::smx_status_type status,
   output logic [15:0]            probability
);
   import smx_pkg::*;

   logic [15:0] score_mem [MAX_LEN];
   logic [15:0] exp_mem [MAX_LEN];
   logic [IDX_W:0] count_ff, count_in;
   logic [IDX_W:0] idx_ff, idx_in;
   logic signed [15:0] max_ff, max_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [15:0] sc_rd_ff, ex_rd_ff;
   logic [15:0] diff;
   logic exp_done, div_done;
   logic [15:0] exp_val, quot;
   logic [IDX_W-1:0] widx;
   logic [IDX_W-1:0] rd_idx;

   assign diff   = 16'(max_ff - $signed(sc_rd_ff));
   assign widx   = count_ff[IDX_W-1:0];
   assign rd_idx = idx_in[IDX_W-1:0];

   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      if (cmd.load) begin
         count_in = count_ff + 1'b1;
         if ($signed(score) > max_ff) begin
            max_in = $signed(score);
         end
      end
      if (exp_done) begin
         sum_in = sum_ff + SUM_W'(exp_val);
         // wrap to the first element once the exp pass is over
         idx_in = (idx_ff + 1'b1 == count_ff) ? '0 : idx_ff + 1'b1;
      end
      if (cmd.emit) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.clear) begin
         count_in = '0;
         max_in   = 16'sh8000;
         sum_in   = '0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= 16'sh8000;
         sum_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         idx_ff   <= idx_in;
      end
   end

   // stores read write-first so a same-cycle write is seen
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         score_mem[widx] <= score;
      end
      if (exp_done) begin
         exp_mem[idx_ff[IDX_W-1:0]] <= exp_val;
      end
      if (cmd.load && widx == rd_idx) begin
         sc_rd_ff <= score;
      end else begin
         sc_rd_ff <= score_mem[rd_idx];
      end
      if (exp_done && idx_ff[IDX_W-1:0] == rd_idx) begin
         ex_rd_ff <= exp_val;
      end else begin
         ex_rd_ff <= exp_mem[rd_idx];
      end
   end

   smx_exp u_exp (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.exp_start),
      .diff   (diff),
      .done   (exp_done),
      .result (exp_val)
   );

   smx_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (ex_rd_ff),
      .den   (sum_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign status.exp_done = exp_done;
   assign status.div_done = div_done;
   assign status.last_idx = (idx_ff + 1'b1 == count_ff);
   assign status.full     = (count_ff == (IDX_W+1)'(MAX_LEN - 1));
   assign probability     = quot;
endmodule

FILE: sv/smx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer: collect, exp pass, divide pass with one result per element.
// ----------------------------------------------------------------------------
module smx_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    last_element,
   input  smx_pkg::smx_status_type status,
   output smx_pkg::smx_cmd_type    cmd,
   output logic                    busy,
   output logic                    strobe,
   output logic                    last_out
);
   import smx_pkg::*;

   typedef enum logic [4:0] {
      S_COLLECT = 5'b00001,
      S_EXP     = 5'b00010,
      S_EXPWAIT = 5'b00100,
      S_DIV     = 5'b01000,
      S_DIVWAIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      strobe   = 1'b0;
      case (state_ff)
         S_COLLECT: begin
            if (start) begin
               cmd.load = 1'b1;
               if (last_element || status.full) begin
                  state_in = S_EXP;
               end
            end
         end
         S_EXP: begin
            cmd.exp_start = 1'b1;
            last_in  = status.last_idx;
            state_in = S_EXPWAIT;
         end
         S_EXPWAIT: begin
            if (status.exp_done) begin
               state_in = last_ff ? S_DIV : S_EXP;
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            last_in  = status.last_idx;
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (status.div_done) begin
               strobe   = 1'b1;
               cmd.emit = 1'b1;
               if (last_ff) begin
                  cmd.clear = 1'b1;
                  state_in  = S_COLLECT;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   assign busy     = (state_ff != S_COLLECT);
   assign last_out = last_ff;

`ifndef NO_ASSERTIONS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_strobe_state: assert property (@(posedge clock) disable iff (reset)
      strobe |-> state_ff == S_DIVWAIT) else $error("strobe outside divide");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy) else $error("load while busy");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (strobe && last_out) |=> !busy) else $error("no return to collect");
`endif
endmodule

FILE: sv/softmax_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_vector
// Max-subtracted softmax over a vector of Q8.8 scores, Q0.16 outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_score/req_last_element with start; a transfer happens when
//   start is high and busy is low. Collection takes one element per cycle.
//   The element flagged last, or the one that fills the store, closes the
//   vector and busy rises.
//   Exp pass: elements go one at a time through the 3-stage exp unit.
//   Divide pass: elements go one at a time through the bit-serial divider.
//   Each probability appears for one cycle with rsp_valid; the final one has
//   rsp_last_result set. The receiver cannot stall; results are not held.
//   The first result follows the whole exp pass and the first divide.
//   Reset (synchronous) returns to collect with an empty vector.
// ----------------------------------------------------------------------------
module softmax_vector #(
   parameter int MAX_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_score,
   input  logic        req_last_element,
   output logic        rsp_valid,
   output logic [15:0] rsp_probability,
   output logic        rsp_last_result
);
   import smx_pkg::*;

   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   smx_cmd_type    cmd;
   smx_status_type status;

   smx_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .last_element (req_last_element),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy),
      .strobe       (rsp_valid),
      .last_out     (rsp_last_result)
   );

   smx_datapath #(.MAX_LEN(MAX_LEN), .IDX_W(IDX_W)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .score       (req_score),
      .status      (status),
      .probability (rsp_probability)
   );
endmodule
